[rtl/core/egsm_pkg.sv]
package egsm_pkg;

  // Grid geometry
  localparam int GRID_X    = 512;
  localparam int GRID_Y    = 512;
  localparam int MAX_VALUE = 100;
  localparam int CELLS     = GRID_X * GRID_Y;
  localparam int IDX_W     = $clog2(CELLS);

  // Divider: 24-bit dividend covers both position offsets and span << 8
  localparam int DIV_W  = 24;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int CS_W   = 12;

  // Configuration register indexes
  localparam logic [3:0] REG_ORIGIN_X   = 4'd0;
  localparam logic [3:0] REG_ORIGIN_Y   = 4'd1;
  localparam logic [3:0] REG_CELL_SIZE  = 4'd2;
  localparam logic [3:0] REG_THRESH     = 4'd3;
  localparam logic [3:0] REG_USE_ELEV   = 4'd4;
  localparam logic [3:0] REG_FILTER_HI  = 4'd5;
  localparam logic [3:0] REG_PERSIST    = 4'd6;
  localparam logic [3:0] REG_SLOPE_MULT = 4'd7;

  // Operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic        filled;
    logic [15:0] top;
    logic [15:0] second;
    logic [15:0] high;
    logic [15:0] bottom;
    logic [7:0]  label;
    logic [15:0] slope;
  } cell_t;

  localparam cell_t CELL_EMPTY = '{
    filled: 1'b0, top: 16'h8000, second: 16'h8000, high: 16'h8000,
    bottom: 16'h7fff, label: 8'd0, slope: 16'd0};

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_ADD_CHK, ST_ADD_DX, ST_ADD_DY, ST_ADD_RG, ST_ADD_WT,
    ST_RC_CHK, ST_RC_WT,
    ST_EF_RD, ST_EF_WT, ST_EF_DV, ST_EF_NX,
    ST_CL_RD, ST_CL_WT, ST_CL_NX
  } state_t;

  typedef enum logic [1:0] {DIV_X, DIV_Y, DIV_SLOPE} div_sel_t;
  typedef enum logic [1:0] {ADDR_POINT, ADDR_READ, ADDR_SWEEP} addr_sel_t;
  typedef enum logic [2:0] {WR_NONE, WR_INIT, WR_EMPTY, WR_POINT, WR_SLOPE} wr_t;
  typedef enum logic [1:0] {RES_ZERO, RES_ACC, RES_READ} res_t;

  typedef struct packed {
    logic      latch;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      div_start;
    div_sel_t  div_sel;
    logic      save_x;
    logic      save_y;
    logic      rd_en;
    addr_sel_t addr_sel;
    wr_t       wr;
    logic      res_load;
    res_t      res;
  } cmd_t;

  typedef struct packed {
    logic pt_skip;
    logic pt_oob;
    logic rd_oob;
    logic frozen;
    logic filled;
    logic span_pos;
    logic cnt_last;
    logic div_done;
  } status_t;

  // Occupancy value of one cell under the current settings
  function automatic logic [7:0] cell_value(cell_t c, logic use_elev,
                                            logic [15:0] thresh,
                                            logic [7:0] mult);
    logic [23:0] prod;
    logic [15:0] v;
    logic [7:0]  r;
    prod = 24'(mult) * 24'(c.slope);
    v    = prod[23:8];
    r    = 8'd0;
    if (c.filled) begin
      if (use_elev) begin
        if ($signed({c.high[15], c.high}) > $signed({1'b0, thresh}))
          r = 8'(MAX_VALUE);
      end else if (c.slope > thresh) begin
        r = (v > 16'(MAX_VALUE)) ? 8'(MAX_VALUE) : v[7:0];
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/egsm_div.sv]
module egsm_div
  import egsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CS_W-1:0]  divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [CS_W-1:0]   rem;
  logic [DCNT_W-1:0] cnt;
  logic [CS_W:0]     shifted;
  logic              fits;

  // one restoring step per cycle
  assign shifted = {rem, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DCNT_W'(DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (cnt != '0) begin
      if (fits) rem <= CS_W'(shifted - {1'b0, divisor});
      else      rem <= shifted[CS_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

[rtl/core/egsm_ctrl.sv]
module egsm_ctrl
  import egsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  status_t    sts,
  output logic       busy,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  assign busy = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:    if (sts.cnt_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_ADD:   state_next = ST_ADD_CHK;
            OP_FRAME: state_next = ST_EF_RD;
            OP_READ:  state_next = ST_RC_CHK;
            default:  state_next = ST_CL_RD;
          endcase
        end
      end
      ST_ADD_CHK: state_next = sts.pt_skip ? ST_IDLE : ST_ADD_DX;
      ST_ADD_DX:  if (sts.div_done) state_next = ST_ADD_DY;
      ST_ADD_DY:  if (sts.div_done) state_next = ST_ADD_RG;
      ST_ADD_RG:  state_next = sts.pt_oob ? ST_IDLE : ST_ADD_WT;
      ST_ADD_WT:  state_next = ST_IDLE;
      ST_RC_CHK:  state_next = sts.rd_oob ? ST_IDLE : ST_RC_WT;
      ST_RC_WT:   state_next = ST_IDLE;
      ST_EF_RD:   state_next = ST_EF_WT;
      ST_EF_WT:   state_next = (sts.filled && sts.span_pos) ? ST_EF_DV : ST_EF_NX;
      ST_EF_DV:   if (sts.div_done) state_next = ST_EF_NX;
      ST_EF_NX:   state_next = sts.cnt_last ? ST_IDLE : ST_EF_RD;
      ST_CL_RD:   state_next = ST_CL_WT;
      ST_CL_WT:   state_next = ST_CL_NX;
      ST_CL_NX:   state_next = sts.cnt_last ? ST_IDLE : ST_CL_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd = '{latch: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, div_start: 1'b0,
            div_sel: DIV_X, save_x: 1'b0, save_y: 1'b0, rd_en: 1'b0,
            addr_sel: ADDR_SWEEP, wr: WR_NONE, res_load: 1'b0, res: RES_ZERO};
    case (state)
      ST_INIT: begin
        cmd.wr      = WR_INIT;
        cmd.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        cmd.latch   = start;
        cmd.cnt_clr = start;
      end
      ST_ADD_CHK: begin
        if (sts.pt_skip) cmd.res_load = 1'b1;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_X;
        end
      end
      ST_ADD_DX: begin
        if (sts.div_done) begin
          cmd.save_x    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_Y;
        end
      end
      ST_ADD_DY: cmd.save_y = sts.div_done;
      ST_ADD_RG: begin
        if (sts.pt_oob) cmd.res_load = 1'b1;
        else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_POINT;
        end
      end
      ST_ADD_WT: begin
        cmd.res_load = 1'b1;
        if (!sts.frozen) begin
          cmd.wr  = WR_POINT;
          cmd.res = RES_ACC;
        end
      end
      ST_RC_CHK: begin
        if (sts.rd_oob) cmd.res_load = 1'b1;
        else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_READ;
        end
      end
      ST_RC_WT: begin
        cmd.res_load = 1'b1;
        cmd.res      = RES_READ;
      end
      ST_EF_RD, ST_CL_RD: cmd.rd_en = 1'b1;
      ST_EF_WT: begin
        if (sts.filled && !sts.span_pos) cmd.wr = WR_SLOPE;
        if (sts.filled && sts.span_pos) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SLOPE;
        end
      end
      ST_EF_DV: if (sts.div_done) cmd.wr = WR_SLOPE;
      ST_CL_WT: if (!sts.frozen) cmd.wr = WR_EMPTY;
      ST_EF_NX, ST_CL_NX: begin
        if (sts.cnt_last) cmd.res_load = 1'b1;
        else              cmd.cnt_inc  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/egsm_dp.sv]
module egsm_dp
  import egsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic        cfg_valid,
  input  logic [3:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic [19:0] pos_x,
  input  logic [19:0] pos_y,
  input  logic [15:0] pos_z,
  input  logic [7:0]  label,
  input  logic        has_label,
  input  logic [8:0]  cell_x,
  input  logic [8:0]  cell_y,
  output logic        result_valid,
  output logic [7:0]  occupancy,
  output logic [7:0]  terrain,
  output logic        accepted,
  output logic        done_res
);

  // configuration
  logic [19:0] origin_x, origin_y;
  logic [11:0] cell_size;
  logic [15:0] slope_thresh;
  logic        use_elevation, filter_highest, persistent;
  logic [7:0]  slope_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= 20'(-25600);
      origin_y       <= 20'(-25600);
      cell_size      <= 12'd128;
      slope_thresh   <= 16'd256;
      use_elevation  <= 1'b0;
      filter_highest <= 1'b0;
      persistent     <= 1'b0;
      slope_mult     <= 8'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x       <= cfg_data;
        REG_ORIGIN_Y:   origin_y       <= cfg_data;
        REG_CELL_SIZE:  cell_size      <= cfg_data[11:0];
        REG_THRESH:     slope_thresh   <= cfg_data[15:0];
        REG_USE_ELEV:   use_elevation  <= cfg_data[0];
        REG_FILTER_HI:  filter_highest <= cfg_data[0];
        REG_PERSIST:    persistent     <= cfg_data[0];
        REG_SLOPE_MULT: slope_mult     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [19:0] px, py;
  logic [15:0] pz;
  logic [7:0]  lab;
  logic        has;
  logic [8:0]  cx, cy;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px  <= pos_x;
      py  <= pos_y;
      pz  <= pos_z;
      lab <= label;
      has <= has_label;
      cx  <= cell_x;
      cy  <= cell_y;
    end
  end

  // offsets from the grid corner
  logic [20:0] dx, dy;
  assign dx = {px[19], px} - {origin_x[19], origin_x};
  assign dy = {py[19], py} - {origin_y[19], origin_y};

  // sweep counter
  logic [IDX_W-1:0] cnt;
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) cnt <= '0;
    else if (cmd.cnt_inc)   cnt <= cnt + 1'b1;
  end

  // memory read side
  cell_t            mem [CELLS];
  cell_t            rdata, wdata;
  logic [IDX_W-1:0] addr, addr_r, waddr;
  logic [DIV_W-1:0] xq, yq;

  // span and value of the cell just read
  logic [16:0] span;
  logic [7:0]  value;
  assign span  = {rdata.high[15], rdata.high} - {rdata.bottom[15], rdata.bottom};
  assign value = cell_value(rdata, use_elevation, slope_thresh, slope_mult);

  // divider
  logic [DIV_W-1:0] div_a, div_q;
  logic [CS_W-1:0]  eff_cs;
  logic             div_done;

  assign eff_cs = (cell_size == '0) ? CS_W'(1) : cell_size;

  always_comb begin
    case (cmd.div_sel)
      DIV_X:   div_a = DIV_W'(dx[19:0]);
      DIV_Y:   div_a = DIV_W'(dy[19:0]);
      default: div_a = {span[15:0], 8'd0};
    endcase
  end

  egsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (eff_cs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.save_x) xq <= div_q;
    if (cmd.save_y) yq <= div_q;
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_POINT: addr = IDX_W'(xq) * IDX_W'(GRID_Y) + IDX_W'(yq);
      ADDR_READ:  addr = IDX_W'(cx) * IDX_W'(GRID_Y) + IDX_W'(cy);
      default:    addr = cnt;
    endcase
  end

  // write data
  logic signed [15:0] h;
  assign h = pz;

  always_comb begin
    wdata = rdata;
    case (cmd.wr)
      WR_INIT, WR_EMPTY: wdata = CELL_EMPTY;
      WR_POINT: begin
        wdata.filled = 1'b1;
        if (filter_highest) begin
          if (h > $signed(rdata.top)) begin
            wdata.second = rdata.top;
            wdata.top    = h;
            wdata.high   = rdata.top;
          end else if (h > $signed(rdata.second)) begin
            wdata.second = h;
            wdata.high   = h;
          end
        end else if (h > $signed(rdata.high)) begin
          wdata.high = h;
        end
        if (h < $signed(rdata.bottom)) wdata.bottom = h;
        if (has && (lab > rdata.label)) wdata.label = lab;
      end
      WR_SLOPE: begin
        if (!sts.span_pos)          wdata.slope = 16'd0;
        else if (div_q[23:16] != '0) wdata.slope = 16'hffff;
        else                         wdata.slope = div_q[15:0];
      end
      default: ;
    endcase
  end

  assign waddr = (cmd.wr == WR_INIT) ? cnt : addr_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata  <= mem[addr];
      addr_r <= addr;
    end
    if (cmd.wr != WR_NONE) mem[waddr] <= wdata;
  end

  // status to the controller
  always_comb begin
    sts.pt_skip  = ((px == '0) && (py == '0)) || dx[20] || dy[20];
    sts.pt_oob   = (xq >= DIV_W'(GRID_X)) || (yq >= DIV_W'(GRID_Y));
    sts.rd_oob   = (32'(cx) >= 32'(GRID_X)) || (32'(cy) >= 32'(GRID_Y));
    sts.frozen   = persistent && (value != 8'd0);
    sts.filled   = rdata.filled;
    sts.span_pos = !span[16] && (span != '0);
    sts.cnt_last = (cnt == IDX_W'(CELLS - 1));
    sts.div_done = div_done;
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      done_res     <= 1'b0;
    end else begin
      result_valid <= cmd.res_load;
      done_res     <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      occupancy <= (cmd.res == RES_READ) ? value : 8'd0;
      terrain   <= (cmd.res == RES_READ) ? rdata.label : 8'd0;
      accepted  <= (cmd.res == RES_ACC);
    end
  end

endmodule

[rtl/core/elevation_grid_slope_map.sv]
// Elevation grid: bins points into a 512 x 512 cell map and reports slope
// or elevation based occupancy per cell.
// Command channel: an op and its fields transfer when start is high and
// busy is low. Ops: add point, end frame, read cell, clear grid.
// Config channel: cfg_index/cfg_data transfer when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Write registers only while idle.
// Result: result_valid pulses for one cycle with occupancy, terrain,
// accepted and done_res; the receiver cannot stall and must take it.
// Add point: two serial divides for the cell index, then a cell
// read-modify-write; a point at the origin or below the grid corner
// returns early without dividing.
// End frame walks every cell, with a serial divide for the slope of a
// filled cell with a positive height span. Clear walks every cell.
// One op is in flight at a time; the cell memory port sets the walk rates.
// Reset: a clearing pass writes all 262144 cells, one per cycle; busy stays
// high until the pass ends and no op is taken before then.
module elevation_grid_slope_map
  import egsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [19:0] pos_x,
  input  logic [19:0] pos_y,
  input  logic [15:0] pos_z,
  input  logic [7:0]  label,
  input  logic        has_label,
  input  logic [8:0]  cell_x,
  input  logic [8:0]  cell_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        result_valid,
  output logic [7:0]  occupancy,
  output logic [7:0]  terrain,
  output logic        accepted,
  output logic        done_res
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  egsm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  egsm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .label        (label),
    .has_label    (has_label),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .result_valid (result_valid),
    .occupancy    (occupancy),
    .terrain      (terrain),
    .accepted     (accepted),
    .done_res     (done_res)
  );

endmodule
